>>> hw/rtl/i2cw_pkg.sv
// shared types and constants for the i2c write waveform generator
// no dependencies
package i2cw_pkg;

    localparam int ADDR_BITS = 7;
    localparam int DATA_BITS = 8;

    // slot numbering: address, write and ack slots first, then data bits, then data ack
    localparam int HDR_SLOTS = ADDR_BITS + 2;
    localparam int SLOT_W    = 5;
    localparam logic [SLOT_W-1:0] FIRST_HDR_SLOT  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] FIRST_DATA_SLOT = SLOT_W'(HDR_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_DATA_SLOT  = SLOT_W'(HDR_SLOTS + DATA_BITS - 1);
    localparam logic [SLOT_W-1:0] ACK_SLOT        = SLOT_W'(HDR_SLOTS + DATA_BITS);

    // samples per slot: low, high, low
    localparam logic [1:0] SUB_HIGH = 2'd1;
    localparam logic [1:0] SUB_LAST = 2'd2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    // one classified byte, data already in transmit order (first bit in msb)
    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic                 header;
        logic                 stop;
    } cmd_t;

endpackage

>>> hw/rtl/i2cw_front.sv
// front end: input handshake, bit order register, packet tracking
// depends on i2cw_pkg
module i2cw_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cw_pkg::DATA_BITS-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                q_full,
    output logic                                q_push,
    output i2cw_pkg::cmd_t                      q_cmd
);

    logic lsb_first_reg;
    logic in_packet_reg;
    logic in_packet_next;
    logic [i2cw_pkg::DATA_BITS-1:0] rev;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        for (int i = 0; i < i2cw_pkg::DATA_BITS; i++) begin
            rev[i] = s_tdata[i2cw_pkg::DATA_BITS-1-i];
        end
    end

    always_comb begin
        q_cmd.data   = lsb_first_reg ? rev : s_tdata;
        q_cmd.header = !in_packet_reg;
        q_cmd.stop   = s_tlast;
    end

    always_comb begin
        in_packet_next = in_packet_reg;
        if (q_push) begin
            in_packet_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsb_first_reg <= 1'b0;
            in_packet_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lsb_first_reg <= cfg_wr_data;
            end
            in_packet_reg <= in_packet_next;
        end
    end

endmodule

>>> hw/rtl/i2cw_cmd_fifo.sv
// short command queue between front and back
// depends on i2cw_pkg
module i2cw_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  i2cw_pkg::cmd_t push_cmd,
    input  logic           pop,
    output i2cw_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    i2cw_pkg::cmd_t mem [i2cw_pkg::FIFO_DEPTH];
    logic [i2cw_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [i2cw_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [i2cw_pkg::FIFO_CW-1:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full    = (count_reg == i2cw_pkg::FIFO_CW'(i2cw_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/i2cw_back.sv
// back end: expands queued commands into line samples, one per cycle while m_ is not stalled
// depends on i2cw_pkg
module i2cw_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  i2cw_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SLOT  = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    logic                               busy_reg,  busy_next;
    logic [1:0]                         phase_reg, phase_next;
    logic [i2cw_pkg::SLOT_W-1:0]        slot_reg,  slot_next;
    logic [1:0]                         sub_reg,   sub_next;
    logic                               idx_reg,   idx_next;
    logic [i2cw_pkg::DATA_BITS-1:0]     sh_reg,    sh_next;
    logic                               stop_reg,  stop_next;

    logic                               out_valid_reg;
    logic                               scl_reg, sda_reg, last_reg;

    // current working state, fresh from the queue head when not busy
    logic [1:0]                         phase;
    logic [i2cw_pkg::SLOT_W-1:0]        slot;
    logic [1:0]                         sub;
    logic                               idx;
    logic [i2cw_pkg::DATA_BITS-1:0]     sh;
    logic                               stop;

    logic active, step;
    logic scl, sda, done;

    assign active = busy_reg || !q_empty;
    assign step   = active && (!out_valid_reg || m_tready);
    assign q_pop  = step && !busy_reg;

    always_comb begin
        if (busy_reg) begin
            phase = phase_reg;
            slot  = slot_reg;
            sub   = sub_reg;
            idx   = idx_reg;
            sh    = sh_reg;
            stop  = stop_reg;
        end else begin
            phase = head.header ? PH_START : PH_SLOT;
            slot  = head.header ? i2cw_pkg::FIRST_HDR_SLOT : i2cw_pkg::FIRST_DATA_SLOT;
            sub   = '0;
            idx   = 1'b0;
            sh    = head.data;
            stop  = head.stop;
        end
    end

    always_comb begin
        scl        = 1'b0;
        sda        = 1'b0;
        done       = 1'b0;
        phase_next = phase;
        slot_next  = slot;
        sub_next   = sub;
        idx_next   = idx;
        sh_next    = sh;
        stop_next  = stop;
        case (phase)
            PH_START: begin
                scl      = 1'b1;
                sda      = !idx;
                idx_next = !idx;
                if (idx) begin
                    phase_next = PH_SLOT;
                    sub_next   = '0;
                end
            end
            PH_SLOT: begin
                scl = (sub == i2cw_pkg::SUB_HIGH);
                sda = (slot >= i2cw_pkg::FIRST_DATA_SLOT) &&
                      (slot <= i2cw_pkg::LAST_DATA_SLOT) && sh[i2cw_pkg::DATA_BITS-1];
                if (sub != i2cw_pkg::SUB_LAST) begin
                    sub_next = sub + 2'd1;
                end else if (slot == i2cw_pkg::ACK_SLOT) begin
                    if (stop) begin
                        phase_next = PH_STOP;
                        idx_next   = 1'b0;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    sub_next  = '0;
                    slot_next = slot + 1'b1;
                    if (slot >= i2cw_pkg::FIRST_DATA_SLOT) begin
                        sh_next = {sh[i2cw_pkg::DATA_BITS-2:0], 1'b0};
                    end
                end
            end
            PH_STOP: begin
                scl      = 1'b1;
                sda      = idx;
                idx_next = !idx;
                done     = idx;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        if (step) begin
            busy_next = !done;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            sub_reg   <= sub_next;
            idx_reg   <= idx_next;
            sh_reg    <= sh_next;
            stop_reg  <= stop_next;
            scl_reg   <= scl;
            sda_reg   <= sda;
            last_reg  <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, sda_reg, scl_reg};
    assign m_tlast  = last_reg;

endmodule

>>> hw/rtl/i2c_write_waveform_generator_core.sv
// top level of the i2c write waveform generator
// depends on i2cw_pkg, i2cw_front, i2cw_cmd_fifo, i2cw_back
//
//  channel   direction  tdata                        tuser  tlast
//  s_        in         [7:0] data_byte              -      last_byte
//  m_        out        [0] scl, [1] sda, rest zero  -      last_sample
//  cfg_      in         wr_data = lsb_first          -      -
//
// one line sample leaves per cycle while m_ is not stalled: 27 samples per byte, 29 more when a packet
// starts and 2 more for the stop; the back end sequencer produces them.
// the front end takes a new byte whenever the two-entry queue has room.
// reset is synchronous and active low; it empties the queue and returns to idle.
// a stall on m_ holds the output register and the sequencer; s_ keeps filling the queue.
module i2c_write_waveform_generator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] scl, [1] sda, [7:2] zero
    output logic       m_tlast
);

    i2cw_pkg::cmd_t push_cmd;
    i2cw_pkg::cmd_t head;
    logic push, pop, full, empty;

    i2cw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (full),
        .q_push      (push),
        .q_cmd       (push_cmd)
    );

    i2cw_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    i2cw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/i2cw_line_checker.sv
`timescale 1ns / 1ps
// line sample checker for the i2c write waveform generator: predicts the scl/sda samples
// of every s_ transfer and compares them with the m_ transfers; depends on i2cw_pkg
module i2cw_line_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] scl, [1] sda, [7:2] zero
    input  logic       m_tlast,
    output int         error_count,
    output int         samples_pending,
    output int         samples_checked
);

    typedef struct packed {
        logic scl;
        logic sda;
        logic last_sample;
    } line_sample_t;

    line_sample_t expected_samples[$];
    logic         lsb_order;
    logic         packet_open;

    task automatic add_sample(input logic scl, input logic sda);
        line_sample_t smp;
        smp.scl         = scl;
        smp.sda         = sda;
        smp.last_sample = 1'b0;
        expected_samples = {expected_samples, smp};
    endtask

    task automatic add_slot(input logic bit_val);
        add_sample(1'b0, bit_val);
        add_sample(1'b1, bit_val);
        add_sample(1'b0, bit_val);
    endtask

    task automatic predict_waveform(input logic [7:0] data_byte, input logic last_byte);
        int pos;
        if (!packet_open) begin
            // start condition, then address, write and ack slots all held low
            add_sample(1'b1, 1'b1);
            add_sample(1'b1, 1'b0);
            repeat (i2cw_pkg::ADDR_BITS + 2) add_slot(1'b0);
            packet_open = 1'b1;
        end
        for (int i = 0; i < i2cw_pkg::DATA_BITS; i++) begin
            pos = lsb_order ? i : i2cw_pkg::DATA_BITS - 1 - i;
            add_slot(data_byte[pos]);
        end
        // ack slot driven low
        add_slot(1'b0);
        if (last_byte) begin
            add_sample(1'b1, 1'b0);
            add_sample(1'b1, 1'b1);
            packet_open = 1'b0;
        end
        expected_samples[expected_samples.size() - 1].last_sample = 1'b1;
    endtask

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        line_sample_t want;
        if (!aresetn) begin
            expected_samples.delete();
            lsb_order   = 1'b0;
            packet_open = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    $error("line sample transfer with nothing expected: tdata %0h tlast %0d",
                           m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    compare_field("scl", int'(want.scl), int'(m_tdata[0]));
                    compare_field("sda", int'(want.sda), int'(m_tdata[1]));
                    compare_field("last_sample", int'(want.last_sample), int'(m_tlast));
                    compare_field("tdata padding", 0, int'(m_tdata[7:2]));
                    samples_checked++;
                end
            end
            if (s_tvalid && s_tready) predict_waveform(s_tdata, s_tlast);
            // register takes effect for transfers after this edge
            if (cfg_wr_en) lsb_order = cfg_wr_data;
        end
        samples_pending = expected_samples.size();
    end

endmodule

>>> tb/i2c_write_waveform_generator_core_tb.sv
`timescale 1ns / 1ps
// top of the i2c write waveform generator testbench: clock, reset, byte stimulus, output
// stalls and verdict; depends on i2c_write_waveform_generator_core and i2cw_line_checker
module i2c_write_waveform_generator_core_tb;

    localparam logic MSB_FIRST = 1'b0;
    localparam logic LSB_FIRST = 1'b1;

    localparam int RANDOM_BYTES = 220;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 600000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int error_count;
    int samples_pending;
    int samples_checked;
    int cycle_count   = 0;
    int burst_left    = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    int order_writes  = 0;
    bit random_phase  = 1'b0;

    i2c_write_waveform_generator_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    i2cw_line_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .error_count     (error_count),
        .samples_pending (samples_pending),
        .samples_checked (samples_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tlast  <= last_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (last_byte) packets_sent++;
    endtask

    // bursts of random length, gaps short or long enough to let the block go idle
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_item(input logic [7:0] data_byte, input logic last_byte);
        send_byte(data_byte, last_byte);
        sender_pause();
    endtask

    // every expected sample has arrived; pending is read away from the rising edge
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (samples_pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_bit_order(input logic order);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        order_writes++;
    endtask

    // receiver: stall rate changes from stretch to stretch, one long hold-off
    initial begin
        int  stall_pct;
        int  mode_left;
        int  hold_delay;
        bit  held_off;
        stall_pct  = 0;
        mode_left  = 0;
        hold_delay = $urandom_range(50, 300);
        held_off   = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (random_phase && !held_off) begin
                if (hold_delay == 0) begin
                    held_off = 1'b1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end else begin
                    hold_delay--;
                end
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 75;
                endcase
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            m_tready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d samples still expected",
                 cycle_count, samples_pending);
        $display("** i2c_write_waveform_generator_core: FAILED **");
        $finish;
    end

    initial begin
        int     pkt_len;
        logic   last_byte;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-byte packets at the extremes and one four-byte packet, msb first
        write_bit_order(MSB_FIRST);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h80, 1'b1);
        send_item(8'h01, 1'b1);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        write_bit_order(LSB_FIRST);
        send_item(8'h01, 1'b1);
        send_item(8'h80, 1'b1);
        send_item(8'hC3, 1'b1);
        send_item(8'h0F, 1'b0);
        send_item(8'hF0, 1'b1);

        // bit order changed inside a packet, between bytes
        send_item(8'h96, 1'b0);
        write_bit_order(MSB_FIRST);
        send_item(8'h96, 1'b0);
        write_bit_order(LSB_FIRST);
        send_item(8'h6B, 1'b1);

        random_phase = 1'b1;
        while (bytes_sent < RANDOM_BYTES) begin
            pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < pkt_len; k++) begin
                last_byte = (k == pkt_len - 1);
                send_item(8'($urandom_range(0, 255)), last_byte);
                if (!last_byte && $urandom_range(0, 14) == 0) write_bit_order(1'($urandom));
            end
            if ($urandom_range(0, 4) == 0) write_bit_order(1'($urandom));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bytes in %0d packets with %0d bit order writes", bytes_sent,
                 packets_sent, order_writes);
        $display("checked %0d line samples, including a %0d cycle output hold-off",
                 samples_checked, LONG_HOLD);
        if (error_count == 0 && samples_pending == 0) begin
            $display("** i2c_write_waveform_generator_core: PASSED **");
        end else begin
            $display("** i2c_write_waveform_generator_core: FAILED **");
        end
        $finish;
    end

endmodule
